@@ src/bounded_deque_with_search_core_defines.svh @@
// Assertion macros for the deque core.
// Each check is clocked on i_clk and held off while i_rst_n is low.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication
`define BDQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BDQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bdq_pkg.sv @@
`default_nettype none

package bdq_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int DEPTH_DEF = 16;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD_FRONT = 3'd0,
        OP_REM_FRONT = 3'd1,
        OP_ADD_BACK  = 3'd2,
        OP_REM_BACK  = 3'd3,
        OP_SEARCH    = 3'd4,
        OP_CLEAR     = 3'd5
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Result flags from the controller
    typedef struct packed {
        logic    done;
        logic    found;
        t_status status;
    } t_res;

endpackage

`default_nettype wire

@@ src/bdq_ram.sv @@
`default_nettype none

// Generic single-port-write, single-port-read RAM with registered read
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/bdq_ctrl.sv @@
`default_nettype none

// Deque controller: ring pointers, fill count and the search sequencer
module bdq_ctrl
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [OP_W-1:0]              i_operation,
    input  wire logic [DATA_W-1:0]            i_value,
    output logic                              o_busy,
    // RAM side
    output logic                              o_we,
    output logic      [$clog2(DEPTH)-1:0]     o_waddr,
    output logic      [DATA_W-1:0]            o_wdata,
    output logic                              o_re,
    output logic      [$clog2(DEPTH)-1:0]     o_raddr,
    input  wire logic [DATA_W-1:0]            i_rdata,
    // Result, valid in the cycle res.done is high
    output t_res                              o_res,
    output logic      [$clog2(DEPTH)-1:0]     o_position,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SRCH = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx,   n_idx;
    logic            r_pend,  n_pend;
    logic [IW-1:0]   r_pend_idx, n_pend_idx;
    logic [DATA_W-1:0] r_value, n_value;

    logic            accept;
    logic            full;
    logic            empty;
    logic            issue;
    logic            match;
    logic [IW-1:0]   front_dec;
    logic [IW-1:0]   front_inc;

    // Ring slot of (base + off), with base + off below twice the depth
    function automatic logic [IW-1:0] f_ring(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign o_busy    = (r_state != S_IDLE);
    assign accept    = i_start && (r_state == S_IDLE);
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - 1'b1;
    assign front_inc = (r_front == IW'(DEPTH - 1)) ? '0 : r_front + 1'b1;

    // Search: one read issued and one compare per cycle, overlapped
    assign issue = (r_state == S_SRCH) && (r_idx < r_count);
    assign match = r_pend && (i_rdata == r_value);

    always_comb begin
        n_state    = r_state;
        n_front    = r_front;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_value    = r_value;
        o_we       = 1'b0;
        o_waddr    = f_ring(r_front, r_count);
        o_wdata    = i_value;
        o_re       = 1'b0;
        o_raddr    = f_ring(r_front, r_idx);
        o_res      = '{done: 1'b0, found: 1'b0, status: ST_OK};
        o_position = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_res.done = 1'b1;
                    case (t_op'(i_operation))
                        OP_ADD_FRONT: begin
                            if (full) begin
                                o_res.status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = front_dec;
                                n_front = front_dec;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_REM_FRONT: begin
                            if (empty) begin
                                o_res.status = ST_EMPTY;
                            end else begin
                                n_front = front_inc;
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_ADD_BACK: begin
                            if (full) begin
                                o_res.status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_REM_BACK: begin
                            if (empty) begin
                                o_res.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            o_res.done = 1'b0;
                            n_state    = S_SRCH;
                            n_idx      = '0;
                            n_value    = i_value;
                        end
                        OP_CLEAR: begin
                            n_front = '0;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SRCH: begin
                o_re       = issue;
                n_pend     = issue;
                n_pend_idx = r_idx[IW-1:0];
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (match) begin
                    o_res.done  = 1'b1;
                    o_res.found = 1'b1;
                    o_position  = r_pend_idx;
                    n_pend      = 1'b0;
                    n_state     = S_IDLE;
                end else if (!issue && !r_pend) begin
                    o_res.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_count = n_count;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    // Search payload
    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_value    <= n_value;
    end

endmodule

`default_nettype wire

@@ src/bounded_deque_with_search_core.sv @@
`default_nettype none
// Channel   Handshake                  Payload
// command   start & !busy              i_operation, i_value
// result    o_done (one-cycle strobe)  o_found, o_position, o_count, o_status
//
// Inserts, removes, clear and unused codes: result strobe in the cycle after the
// transfer; busy stays low, so a new command may follow in the next cycle.
// Search: the ring is walked one RAM read per cycle (read and compare overlapped);
// busy stays high until a match or the end of the ring, and the result strobe
// comes in the same cycle that busy drops.
// Reset (synchronous, active low) empties the ring; RAM contents are left as is.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "bounded_deque_with_search_core_defines.svh"

module bounded_deque_with_search_core
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [OP_W-1:0]            i_operation,
    input  wire logic signed [DATA_W-1:0]   i_value,
    output logic                            o_done,
    output logic                            o_found,
    output logic      [$clog2(DEPTH)-1:0]   o_position,
    output logic      [$clog2(DEPTH+1)-1:0] o_count,
    output logic      [1:0]                 o_status
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              we;
    logic [IW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;
    t_res              res;
    logic [IW-1:0]     res_position;
    logic [CW-1:0]     res_count;

    logic              r_done;
    logic              r_found;
    logic [IW-1:0]     r_position;
    logic [CW-1:0]     r_count;
    t_status           r_status;

    bdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_busy      (busy),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_res       (res),
        .o_position  (res_position),
        .o_count     (res_count)
    );

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= res.done;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_found    <= res.found;
        r_position <= res_position;
        r_count    <= res_count;
        r_status   <= res.status;
    end

    assign o_done     = r_done;
    assign o_found    = r_found;
    assign o_position = r_position;
    assign o_count    = r_count;
    assign o_status   = r_status;

    // Checks
    `BDQ_ASSERT_IMP(a_count_bound, o_done, o_count <= CW'(DEPTH), "count above depth")
    `BDQ_ASSERT_IMP(a_full_count, o_done && (o_status == ST_FULL), o_count == CW'(DEPTH), "full status with room left")
    `BDQ_ASSERT_NXT(a_search_busy, start && !busy && (i_operation == OP_SEARCH), busy, "search did not start")
    `BDQ_ASSERT_NXT(a_quick_done, start && !busy && (i_operation != OP_SEARCH), o_done && !o_found, "missing quick result")

endmodule

`default_nettype wire
